FILE: rtl/alias_table_sampler_assert.svh
// Assertion macros for the alias table sampler checker.
// Used by ats_checker.sv only; no other dependencies.
`ifndef ALIAS_TABLE_SAMPLER_ASSERT_SVH
`define ALIAS_TABLE_SAMPLER_ASSERT_SVH

// Property checked at every edge, reset included.
`define ATS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("alias table sampler check failed");

// Implication checked outside reset.
`define ATS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("alias table sampler check failed");

// Next-cycle implication checked outside reset.
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("alias table sampler check failed");

`endif

FILE: rtl/ats_pkg.sv
// Shared types and constants of the alias table sampler.
// No dependencies.
`timescale 1ns / 1ps

package ats_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int WEIGHT_BITS = 16;

    localparam int ADDR_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_W    = WEIGHT_BITS + CNT_W;
    localparam int UNI_W    = 32;
    localparam int PROD_W   = UNI_W + CNT_W;
    localparam int HI_W     = UNI_W + TOT_W;
    localparam int DEN_W    = CNT_W + TOT_W;
    localparam int IDX_W    = 8;
    localparam int PROB_W   = 33;
    localparam int STAT_W   = 3;
    localparam int CMD_W    = 2;
    localparam int WFLD_W   = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 80;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_B_INIT, ST_B_RD, ST_B_WR,
        ST_P_CHK, ST_P_S2, ST_P_B, ST_P_U, ST_G_CHK, ST_G_W,
        ST_D_MUL, ST_D_RD, ST_D_CMP, ST_Q_INIT, ST_Q_RD, ST_Q_ACC, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_B_INIT, OP_B_RD, OP_B_WR,
        OP_P_CHK, OP_P_S2, OP_P_B, OP_P_U, OP_G_CHK, OP_G_W,
        OP_D_MUL, OP_D_RD, OP_D_CMP, OP_Q_INIT, OP_Q_RD, OP_Q_ACC
    } op_t;

    typedef struct packed {
        op_t  op;
        logic capture;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic st_zero;
        logic bt_zero;
        logic k_last;
        logic build_go;
        logic q_oor;
        logic table_ready;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/alias_table_sampler.sv
// Top level of the integer Walker alias sampler.
// Depends on ats_pkg, ats_ctrl, ats_dp (and ats_ram below it).
`timescale 1ns / 1ps
//
//  channel | direction | payload
//  s_      | in        | tuser cmd, tdata weight/uniform/query_index, tlast
//  m_      | out       | tuser status, tdata sample_index/prob_numerator/prob_denominator
//
// One beat is taken in idle, then its result is produced:
//   load without last: load step; draw: two multiplies, one table read and a compare;
//   query: init step, then read and accumulate per table entry through the RAM read port;
//   build after last: scaling per entry, then check, small, big, update per pairing step.
// Reset clears count, total, stack tops, the built flag and the output valid.
// A stalled result sits in the output register; the next beat is still taken and
// worked, and its result waits in the done state until the register frees.

module alias_table_sampler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] weight, [47:16] uniform, [55:48] query_index
    input  logic [ats_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    // [1:0] cmd
    input  logic [ats_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] sample_index, [40:8] prob_numerator, [73:41] prob_denominator
    output logic [ats_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [ats_pkg::STAT_W-1:0]      m_tuser
);
    import ats_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: load, table build, draw and query steps
    ats_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tuser(s_tuser), .s_tready(s_tready),
        .stat(stat), .cmd(cmd)
    );

    // tables, stacks, arithmetic and output register
    ats_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cmd(cmd), .stat(stat)
    );

endmodule

FILE: rtl/ats_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ats_ctrl.sv
// Controller state machine of the alias table sampler.
// Depends on ats_pkg; drives ats_dp through dp_cmd_t.
`timescale 1ns / 1ps

module ats_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic [ats_pkg::CMD_W-1:0] s_tuser,
    output logic                     s_tready,
    input  ats_pkg::dp_stat_t        stat,
    output ats_pkg::dp_cmd_t         cmd
);
    import ats_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == CMD_LOAD) begin
                        state_next = ST_LOAD;
                    end else if (s_tuser == CMD_DRAW && stat.table_ready) begin
                        state_next = ST_D_MUL;
                    end else if (s_tuser == CMD_QUERY && stat.table_ready) begin
                        state_next = ST_Q_INIT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD:   state_next = stat.build_go ? ST_B_INIT : ST_DONE;
            ST_B_INIT: state_next = ST_B_RD;
            ST_B_RD:   state_next = ST_B_WR;
            ST_B_WR:   state_next = stat.k_last ? ST_P_CHK : ST_B_RD;
            ST_P_CHK:  state_next = stat.st_zero ? ST_G_CHK : ST_P_S2;
            ST_P_S2:   state_next = stat.bt_zero ? ST_P_CHK : ST_P_B;
            ST_P_B:    state_next = ST_P_U;
            ST_P_U:    state_next = ST_P_CHK;
            ST_G_CHK:  state_next = stat.bt_zero ? ST_DONE : ST_G_W;
            ST_G_W:    state_next = ST_G_CHK;
            ST_D_MUL:  state_next = ST_D_RD;
            ST_D_RD:   state_next = ST_D_CMP;
            ST_D_CMP:  state_next = ST_DONE;
            ST_Q_INIT: state_next = stat.q_oor ? ST_DONE : ST_Q_RD;
            ST_Q_RD:   state_next = ST_Q_ACC;
            ST_Q_ACC:  state_next = stat.k_last ? ST_DONE : ST_Q_RD;
            ST_DONE:   state_next = stat.out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.emit    = (state_reg == ST_DONE) && stat.out_free;
        s_tready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_LOAD:   cmd.op = OP_LOAD;
            ST_B_INIT: cmd.op = OP_B_INIT;
            ST_B_RD:   cmd.op = OP_B_RD;
            ST_B_WR:   cmd.op = OP_B_WR;
            ST_P_CHK:  cmd.op = OP_P_CHK;
            ST_P_S2:   cmd.op = OP_P_S2;
            ST_P_B:    cmd.op = OP_P_B;
            ST_P_U:    cmd.op = OP_P_U;
            ST_G_CHK:  cmd.op = OP_G_CHK;
            ST_G_W:    cmd.op = OP_G_W;
            ST_D_MUL:  cmd.op = OP_D_MUL;
            ST_D_RD:   cmd.op = OP_D_RD;
            ST_D_CMP:  cmd.op = OP_D_CMP;
            ST_Q_INIT: cmd.op = OP_Q_INIT;
            ST_Q_RD:   cmd.op = OP_Q_RD;
            ST_Q_ACC:  cmd.op = OP_Q_ACC;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: rtl/ats_dp.sv
// Datapath of the alias table sampler: table RAMs, stacks, counters,
// multipliers and the output register. Depends on ats_pkg and ats_ram.
`timescale 1ns / 1ps

module ats_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ats_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic [ats_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ats_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [ats_pkg::STAT_W-1:0]       m_tuser,
    input  ats_pkg::dp_cmd_t                 cmd,
    output ats_pkg::dp_stat_t                stat
);
    import ats_pkg::*;

    // control state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TOT_W-1:0]  tot_reg, tot_next;
    logic              ready_reg, ready_next;
    logic [CNT_W-1:0]  st_reg, st_next;
    logic [CNT_W-1:0]  bt_reg, bt_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // payload
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] s_reg, s_next;
    logic [ADDR_W-1:0] b_reg, b_next;
    logic [ADDR_W-1:0] c_reg, c_next;
    logic [TOT_W-1:0]  d_reg, d_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TOT_W-1:0]  hi_reg, hi_next;
    logic [WEIGHT_BITS-1:0] w_in_reg, w_in_next;
    logic              last_in_reg, last_in_next;
    logic [UNI_W-1:0]  u_in_reg, u_in_next;
    logic [IDX_W-1:0]  q_in_reg, q_in_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PROB_W-1:0] num_reg, num_next;
    logic [PROB_W-1:0] den_reg, den_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0] m_tuser_reg, m_tuser_next;

    // RAM ports
    logic              wt_we, thr_we, al_we, sm_we, bg_we;
    logic [ADDR_W-1:0] wt_waddr, thr_waddr, al_waddr, sm_waddr, bg_waddr;
    logic [ADDR_W-1:0] wt_raddr, thr_raddr, al_raddr, sm_raddr, bg_raddr;
    logic [WEIGHT_BITS-1:0] wt_rdata;
    logic [TOT_W-1:0]  thr_wdata, thr_rdata;
    logic [ADDR_W-1:0] al_wdata, al_rdata, sm_wdata, sm_rdata, bg_wdata, bg_rdata;

    // arithmetic
    logic [CNT_W-1:0]  cnt_eff, load_cnt, st_dec, bt_dec, c_wide, q_ext;
    logic [TOT_W-1:0]  tot_eff, load_tot, thr_scaled, nb;
    logic              load_ok, load_zero;
    logic [HI_W-1:0]   fprod;
    logic [DEN_W-1:0]  dprod;
    logic [ADDR_W-1:0] c_sel;

    ats_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_wt_ram (
        .aclk(aclk), .we(wt_we), .waddr(wt_waddr), .wdata(w_in_reg),
        .raddr(wt_raddr), .rdata(wt_rdata)
    );
    ats_ram #(.WIDTH(TOT_W), .DEPTH(MAX_ENTRIES)) u_thr_ram (
        .aclk(aclk), .we(thr_we), .waddr(thr_waddr), .wdata(thr_wdata),
        .raddr(thr_raddr), .rdata(thr_rdata)
    );
    ats_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_al_ram (
        .aclk(aclk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
        .raddr(al_raddr), .rdata(al_rdata)
    );
    ats_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_sm_ram (
        .aclk(aclk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
        .raddr(sm_raddr), .rdata(sm_rdata)
    );
    ats_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_ENTRIES)) u_bg_ram (
        .aclk(aclk), .we(bg_we), .waddr(bg_waddr), .wdata(bg_wdata),
        .raddr(bg_raddr), .rdata(bg_rdata)
    );

    // load bookkeeping: a finished table is dropped by the next load
    always_comb begin
        cnt_eff   = ready_reg ? '0 : cnt_reg;
        tot_eff   = ready_reg ? '0 : tot_reg;
        load_ok   = cnt_eff < MAX_CNT;
        load_cnt  = load_ok ? cnt_eff + 1'b1 : cnt_eff;
        load_tot  = load_ok ? tot_eff + TOT_W'(w_in_reg) : tot_eff;
        load_zero = (load_cnt == '0) || (load_tot == '0);
    end

    always_comb begin
        st_dec     = st_reg - 1'b1;
        bt_dec     = bt_reg - 1'b1;
        thr_scaled = TOT_W'(wt_rdata) * TOT_W'(cnt_reg);
        nb         = thr_rdata - d_reg;
        fprod      = HI_W'(prod_reg[UNI_W-1:0]) * HI_W'(tot_reg);
        dprod      = DEN_W'(cnt_reg) * DEN_W'(tot_reg);
        c_wide     = prod_reg[PROD_W-1:UNI_W];
        if (c_wide >= cnt_reg) begin
            c_wide = cnt_reg - 1'b1;
        end
        c_sel      = c_wide[ADDR_W-1:0];
        q_ext      = CNT_W'(q_in_reg);
    end

    always_comb begin
        stat.st_zero     = (st_reg == '0);
        stat.bt_zero     = (bt_reg == '0);
        stat.k_last      = (CNT_W'(k_reg) == cnt_reg - 1'b1);
        stat.build_go    = last_in_reg && !load_zero;
        stat.q_oor       = (q_ext >= cnt_reg);
        stat.table_ready = ready_reg;
        stat.out_free    = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        cnt_next = cnt_reg;   tot_next = tot_reg;   ready_next = ready_reg;
        st_next  = st_reg;    bt_next  = bt_reg;    k_next = k_reg;
        s_next   = s_reg;     b_next   = b_reg;     c_next = c_reg;
        d_next   = d_reg;     prod_next = prod_reg; hi_next = hi_reg;
        w_in_next = w_in_reg; last_in_next = last_in_reg;
        u_in_next = u_in_reg; q_in_next = q_in_reg;
        idx_next = idx_reg;   num_next = num_reg;   den_next = den_reg;
        stat_next = stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        wt_we = 1'b0;  wt_waddr = cnt_eff[ADDR_W-1:0];  wt_raddr = k_reg;
        thr_we = 1'b0; thr_waddr = k_reg; thr_wdata = tot_reg; thr_raddr = k_reg;
        al_we = 1'b0;  al_waddr = k_reg;  al_wdata = k_reg;   al_raddr = k_reg;
        sm_we = 1'b0;  sm_waddr = st_reg[ADDR_W-1:0]; sm_wdata = k_reg;
        sm_raddr = st_dec[ADDR_W-1:0];
        bg_we = 1'b0;  bg_waddr = bt_reg[ADDR_W-1:0]; bg_wdata = k_reg;
        bg_raddr = bt_dec[ADDR_W-1:0];

        if (cmd.capture) begin
            w_in_next    = s_tdata[WEIGHT_BITS-1:0];
            last_in_next = s_tlast;
            u_in_next    = s_tdata[WFLD_W +: UNI_W];
            q_in_next    = s_tdata[WFLD_W + UNI_W +: IDX_W];
            idx_next     = '0;
            num_next     = '0;
            den_next     = '0;
            stat_next    = ((s_tuser == CMD_DRAW || s_tuser == CMD_QUERY) && !ready_reg)
                           ? STAT_NOT_BUILT : STAT_OK;
        end

        unique case (cmd.op)
            OP_LOAD: begin
                ready_next = 1'b0;
                wt_we      = load_ok;
                if (!load_ok) begin
                    stat_next = STAT_FULL;
                end
                cnt_next = load_cnt;
                tot_next = load_tot;
                if (last_in_reg && load_zero) begin
                    stat_next = STAT_ZERO;
                    cnt_next  = '0;
                    tot_next  = '0;
                end
            end
            OP_B_INIT: begin
                k_next  = '0;
                st_next = '0;
                bt_next = '0;
            end
            OP_B_RD: begin
                wt_raddr = k_reg;
            end
            OP_B_WR: begin
                thr_we    = 1'b1;
                thr_waddr = k_reg;
                thr_wdata = thr_scaled;
                if (thr_scaled < tot_reg) begin
                    sm_we   = 1'b1;
                    st_next = st_reg + 1'b1;
                end else begin
                    bg_we   = 1'b1;
                    bt_next = bt_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
            end
            OP_P_CHK: begin
                if (st_reg != '0) begin
                    st_next = st_dec;
                end
            end
            OP_P_S2: begin
                s_next = sm_rdata;
                if (bt_reg == '0) begin
                    // no big left: the small entry keeps itself
                    al_we     = 1'b1;
                    al_waddr  = sm_rdata;
                    al_wdata  = sm_rdata;
                    thr_we    = 1'b1;
                    thr_waddr = sm_rdata;
                    thr_wdata = tot_reg;
                end else begin
                    bt_next   = bt_dec;
                    thr_raddr = sm_rdata;
                end
            end
            OP_P_B: begin
                b_next    = bg_rdata;
                d_next    = tot_reg - thr_rdata;
                al_we     = 1'b1;
                al_waddr  = s_reg;
                al_wdata  = bg_rdata;
                thr_raddr = bg_rdata;
            end
            OP_P_U: begin
                thr_we    = 1'b1;
                thr_waddr = b_reg;
                thr_wdata = nb;
                if (nb < tot_reg) begin
                    sm_we    = 1'b1;
                    sm_wdata = b_reg;
                    st_next  = st_reg + 1'b1;
                end else if (nb > tot_reg) begin
                    bg_we    = 1'b1;
                    bg_wdata = b_reg;
                    bt_next  = bt_reg + 1'b1;
                end else begin
                    al_we    = 1'b1;
                    al_waddr = b_reg;
                    al_wdata = b_reg;
                end
            end
            OP_G_CHK: begin
                if (bt_reg == '0) begin
                    ready_next = 1'b1;
                end else begin
                    bt_next = bt_dec;
                end
            end
            OP_G_W: begin
                al_we     = 1'b1;
                al_waddr  = bg_rdata;
                al_wdata  = bg_rdata;
                thr_we    = 1'b1;
                thr_waddr = bg_rdata;
                thr_wdata = tot_reg;
            end
            OP_D_MUL: begin
                prod_next = PROD_W'(u_in_reg) * PROD_W'(cnt_reg);
            end
            OP_D_RD: begin
                c_next    = c_sel;
                thr_raddr = c_sel;
                al_raddr  = c_sel;
                hi_next   = fprod[HI_W-1:UNI_W];
            end
            OP_D_CMP: begin
                idx_next = (hi_reg < thr_rdata) ? IDX_W'(c_reg) : IDX_W'(al_rdata);
            end
            OP_Q_INIT: begin
                den_next = dprod[PROB_W-1:0];
                k_next   = '0;
                if (q_ext >= cnt_reg) begin
                    stat_next = STAT_RANGE;
                end
            end
            OP_Q_RD: begin
                thr_raddr = k_reg;
                al_raddr  = k_reg;
            end
            OP_Q_ACC: begin
                if (CNT_W'(k_reg) == q_ext) begin
                    num_next = num_reg + PROB_W'(thr_rdata);
                end else if (CNT_W'(al_rdata) == q_ext) begin
                    num_next = num_reg + PROB_W'(tot_reg - thr_rdata);
                end
                k_next = k_reg + 1'b1;
            end
            default: begin
            end
        endcase

        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TDATA_W'({den_reg, num_reg, idx_reg});
            m_tuser_next  = stat_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            tot_reg      <= '0;
            ready_reg    <= 1'b0;
            st_reg       <= '0;
            bt_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            tot_reg      <= tot_next;
            ready_reg    <= ready_next;
            st_reg       <= st_next;
            bt_reg       <= bt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        s_reg       <= s_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        hi_reg      <= hi_next;
        w_in_reg    <= w_in_next;
        last_in_reg <= last_in_next;
        u_in_reg    <= u_in_next;
        q_in_reg    <= q_in_next;
        idx_reg     <= idx_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        stat_reg    <= stat_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/ats_checker.sv
// Port-level checks of the alias table sampler, bound to the top level.
// Depends on ats_pkg and alias_table_sampler_assert.svh.
`timescale 1ns / 1ps
`include "alias_table_sampler_assert.svh"

module ats_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ats_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [ats_pkg::STAT_W-1:0]      m_tuser
);
    import ats_pkg::*;

    `ATS_ASSERT_ALWAYS(a_rst_clears_valid, !aresetn |=> !m_tvalid)
    `ATS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `ATS_ASSERT_NEXT(a_one_beat_in_flight, s_tvalid && s_tready, !s_tready)
    `ATS_ASSERT_IMPLY(a_status_code, m_tvalid, !(m_tuser[2] && (m_tuser[1:0] != 2'd0)))
    `ATS_ASSERT_IMPLY(a_not_built_zero, m_tvalid && (m_tuser == STAT_NOT_BUILT), m_tdata == '0)

endmodule

bind alias_table_sampler ats_checker u_ats_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);

FILE: tb/tb_alias_table_sampler.sv
// Self-checking bench for the Walker alias table sampler.
// Depends on ats_pkg and alias_table_sampler; builds its own table model.
`timescale 1ns / 1ps

// Keeps its own copy of the weight file and the built table, and queues the
// result that each accepted input beat must produce.
class alias_scoreboard;
    typedef struct {
        logic [7:0]  idx;
        logic [32:0] num;
        logic [32:0] den;
        logic [2:0]  st;
    } sampler_result_t;

    sampler_result_t pending[$];
    longint unsigned wts[256];
    longint unsigned thr[256];
    int unsigned     alias_of[256];
    int unsigned     k_cnt;
    longint unsigned total;
    bit              ready;
    int unsigned     n_builds;

    function new();
        k_cnt = 0;
        total = 0;
        ready = 0;
        n_builds = 0;
    endfunction

    // Scale by K, then pair smalls with bigs on two LIFO stacks.
    function void build_pairs();
        int unsigned sm[256];
        int unsigned bg[256];
        int unsigned st_n, bg_n, s, b, k;
        longint unsigned d;
        st_n = 0;
        bg_n = 0;
        for (k = 0; k < k_cnt; k++) begin
            thr[k] = wts[k] * k_cnt;
            if (thr[k] < total) begin
                sm[st_n] = k;
                st_n++;
            end else begin
                bg[bg_n] = k;
                bg_n++;
            end
        end
        while (st_n > 0) begin
            st_n--;
            s = sm[st_n];
            if (bg_n == 0) begin
                alias_of[s] = s;
                thr[s] = total;
            end else begin
                bg_n--;
                b = bg[bg_n];
                alias_of[s] = b;
                d = total - thr[s];
                thr[b] -= d;
                if (thr[b] < total) begin
                    sm[st_n] = b;
                    st_n++;
                end else if (thr[b] > total) begin
                    bg[bg_n] = b;
                    bg_n++;
                end else begin
                    alias_of[b] = b;
                end
            end
        end
        while (bg_n > 0) begin
            bg_n--;
            b = bg[bg_n];
            alias_of[b] = b;
            thr[b] = total;
        end
    endfunction

    function void note_beat(logic [1:0] cmd, logic [15:0] w, logic last,
                            logic [31:0] u, logic [7:0] q);
        sampler_result_t r;
        longint unsigned prod, frac, hi, sum;
        int unsigned c, i;
        r.idx = '0;
        r.num = '0;
        r.den = '0;
        r.st  = ats_pkg::STAT_OK;
        case (cmd)
            ats_pkg::CMD_LOAD: begin
                if (ready) begin
                    ready = 0;
                    k_cnt = 0;
                    total = 0;
                end
                if (k_cnt < 256) begin
                    wts[k_cnt] = w;
                    k_cnt++;
                    total += w;
                end else begin
                    r.st = ats_pkg::STAT_FULL;
                end
                if (last) begin
                    if (k_cnt == 0 || total == 0) begin
                        r.st = ats_pkg::STAT_ZERO;
                        k_cnt = 0;
                        total = 0;
                    end else begin
                        build_pairs();
                        ready = 1;
                        n_builds++;
                    end
                end
            end
            ats_pkg::CMD_DRAW: begin
                if (!ready) begin
                    r.st = ats_pkg::STAT_NOT_BUILT;
                end else begin
                    prod = longint'(u) * k_cnt;
                    c = prod >> 32;
                    frac = prod & 64'hFFFF_FFFF;
                    if (c >= k_cnt) c = k_cnt - 1;
                    hi = (frac * total) >> 32;
                    r.idx = (hi < thr[c]) ? c[7:0] : alias_of[c][7:0];
                end
            end
            ats_pkg::CMD_QUERY: begin
                if (!ready) begin
                    r.st = ats_pkg::STAT_NOT_BUILT;
                end else begin
                    r.den = 33'(longint'(k_cnt) * total);
                    if (q >= k_cnt) begin
                        r.st = ats_pkg::STAT_RANGE;
                    end else begin
                        sum = 0;
                        for (i = 0; i < k_cnt; i++) begin
                            if (i == q) sum += thr[i];
                            else if (alias_of[i] == q) sum += total - thr[i];
                        end
                        r.num = 33'(sum);
                    end
                end
            end
            default: ;  // spare command: nothing changes, all zeros
        endcase
        pending.push_back(r);
    endfunction

    // Returns 1 when the beat matches the oldest expectation.
    function bit check_beat(logic [79:0] td, logic [2:0] tu, output string msg);
        sampler_result_t r;
        r = pending.pop_front();
        msg = "";
        if (td[7:0] !== r.idx || td[40:8] !== r.num || td[73:41] !== r.den
            || tu !== r.st) begin
            $sformat(msg, "got idx %0d num %0d den %0d st %0d, want %0d %0d %0d %0d",
                     td[7:0], td[40:8], td[73:41], tu, r.idx, r.num, r.den, r.st);
            return 0;
        end
        return 1;
    endfunction
endclass

module tb_alias_table_sampler;
    import ats_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int STALL_LIMIT = 20000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    alias_scoreboard sampler_sb;
    int unsigned     mismatches;
    int unsigned     beats_sent;
    int unsigned     results_seen;
    int unsigned     n_draws, n_queries;
    int unsigned     idle_cycles;
    int unsigned     cycle_no;
    int unsigned     burst_left;

    alias_table_sampler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report(input string what);
        $display("MISMATCH @%0d: %s", cycle_no, what);
        mismatches++;
    endtask

    // Monitor: both handshakes sampled at the rising edge.
    always @(posedge aclk) begin
        string msg;
        cycle_no++;
        if (aresetn) begin
            idle_cycles++;
            if (s_tvalid && s_tready) begin
                sampler_sb.note_beat(s_tuser, s_tdata[15:0], s_tlast,
                                     s_tdata[47:16], s_tdata[55:48]);
                idle_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                idle_cycles = 0;
                if (sampler_sb.pending.size() == 0)
                    report("result beat with nothing expected");
                else if (!sampler_sb.check_beat(m_tdata, m_tuser, msg))
                    report(msg);
            end
            // Watchdog: nothing moved for too long.
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: mixes always-ready stretches, random stalls and a sparse
    // pattern; one long hold-off so the output register backs up.
    initial begin : receiver
        int unsigned mode, len, n;
        bit held;
        held = 0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!held && cycle_no > 600) begin
                held = 1;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            mode = $urandom_range(0, 2);
            len = $urandom_range(20, 150);
            for (n = 0; n < len; n++) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= (n % 3 == 0);
                endcase
            end
        end
    end

    // Sender: bursts of back-to-back beats with random gaps.
    task automatic send_beat(input logic [1:0] cmd, input logic [15:0] w,
                             input logic last, input logic [31:0] u,
                             input logic [7:0] q);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {q, u, w};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        beats_sent++;
    endtask

    // Unused fields carry random bits so every input bit toggles.
    task automatic load_w(input logic [15:0] w, input logic last);
        send_beat(CMD_LOAD, w, last, $urandom, 8'($urandom));
    endtask

    task automatic draw(input logic [31:0] u);
        send_beat(CMD_DRAW, 16'($urandom), 1'($urandom), u, 8'($urandom));
        n_draws++;
    endtask

    task automatic query(input logic [7:0] q);
        send_beat(CMD_QUERY, 16'($urandom), 1'($urandom), $urandom, q);
        n_queries++;
    endtask

    function automatic logic [15:0] pick_weight(input int unsigned style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h0001;
                    default: return 16'($urandom);
                endcase
            end
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_uniform();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Load one table, then draw and query against it.
    task automatic table_round(input int unsigned k, input int unsigned style,
                               input int unsigned draws, input int unsigned queries);
        int unsigned i;
        for (i = 0; i < k; i++)
            load_w(pick_weight(style), i == k - 1);
        for (i = 0; i < draws; i++)
            draw(pick_uniform());
        for (i = 0; i < queries; i++)
            query(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                              : 8'($urandom_range(0, k + 1)));
    endtask

    initial begin : stimulus
        int unsigned k, style, big_done;
        sampler_sb   = new();
        mismatches   = 0;
        beats_sent   = 0;
        results_seen = 0;
        n_draws      = 0;
        n_queries    = 0;
        idle_cycles  = 0;
        cycle_no     = 0;
        burst_left   = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = CMD_LOAD;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: not built, spare command, zero total, extremes.
        draw(32'h8000_0000);
        query(8'd0);
        send_beat(CMD_SPARE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        load_w(16'h0000, 1'b1);
        load_w(16'hFFFF, 1'b0);
        load_w(16'h0000, 1'b0);
        load_w(16'h0001, 1'b0);
        load_w(16'h8000, 1'b1);
        draw(32'h0000_0000);
        draw(32'hFFFF_FFFF);
        draw(32'h8000_0000);
        query(8'd0);
        query(8'd1);
        query(8'd2);
        query(8'd3);
        query(8'd4);
        query(8'hFF);
        load_w(16'hFFFF, 1'b1);
        draw(32'h1234_5678);
        query(8'd0);
        query(8'd1);
        // Pending load, never finished: draws see an unbuilt table.
        load_w(16'h00FF, 1'b0);
        draw($urandom);
        query(8'd0);

        // Random: mostly small tables, a few full ones and one overfull.
        big_done = 0;
        while (beats_sent < 1550) begin
            style = $urandom_range(0, 9);
            style = (style < 4) ? 0 : (style < 6) ? 1 : (style < 9) ? 2 : 3;
            if (big_done < 3 && beats_sent > 300 + 300 * big_done) begin
                k = (big_done == 2) ? 258 : 256;
                table_round(k, style == 3 ? 0 : style, 30, 2);
                big_done++;
            end else begin
                k = $urandom_range(1, 12);
                table_round(k, style, $urandom_range(0, 12), $urandom_range(0, 4));
            end
            // Noise: spare commands, stray draws, unfinished loads.
            case ($urandom_range(0, 9))
                0: send_beat(CMD_SPARE, 16'($urandom), 1'($urandom), $urandom,
                             8'($urandom));
                1: begin
                    load_w(pick_weight(0), 1'b0);
                    draw($urandom);
                end
                default: ;
            endcase
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sampler_sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("Sent %0d beats: %0d tables built, %0d draws, %0d queries, %0d results.",
                 beats_sent, sampler_sb.n_builds, n_draws, n_queries, results_seen);
        $display("Included unbuilt, zero-total, overfull and out-of-range cases.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
